// ===== hdl/lcfb_pkg.sv =====
// Package for the length-prefixed CRC-32 frame builder.
// Item types, the internal job struct and the byte-wise CRC-32 table.
// No dependencies.
`default_nettype none

package lcfb_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
  } out_item_t;

  // one accepted item as handed to the byte sequencer
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] hdr_len;
    logic        first;
    logic        last;
  } job_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t build_crc_table();
    crc_tab_t    tab;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = {i[7:0], 24'h0};
      for (int k = 0; k < 8; k++) begin
        c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      end
      tab[i[7:0]] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t CRC_TABLE = build_crc_table();

  // MSB-first CRC update by one byte
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    return {crc[23:0], 8'h00} ^ CRC_TABLE[crc[31:24] ^ b];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lcfb_emitter.sv =====
// Byte sequencer: holds one job and emits header, payload and CRC bytes
// through a registered output, with the running CRC. Depends on lcfb_pkg.
`default_nettype none

module lcfb_emitter import lcfb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_valid,
  input  wire job_t      job,
  output logic           job_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam logic [2:0] PH_HDR_HI = 3'd0;
  localparam logic [2:0] PH_HDR_LO = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_CRC3   = 3'd3;
  localparam logic [2:0] PH_CRC2   = 3'd4;
  localparam logic [2:0] PH_CRC1   = 3'd5;
  localparam logic [2:0] PH_CRC0   = 3'd6;

  logic        busy_r;
  logic [2:0]  phase_r, phase_nxt;
  job_t        job_r;
  logic [31:0] crc_r, crc_nxt;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        emit, final_byte;
  logic [7:0]  byte_sel;

  always_comb begin
    byte_sel  = job_r.data_byte;
    crc_nxt   = crc_r;
    phase_nxt = phase_r;
    case (phase_r)
      PH_HDR_HI: begin
        byte_sel  = job_r.hdr_len[15:8];
        crc_nxt   = crc_feed(32'h0, byte_sel);
        phase_nxt = PH_HDR_LO;
      end
      PH_HDR_LO: begin
        byte_sel  = job_r.hdr_len[7:0];
        crc_nxt   = crc_feed(crc_r, byte_sel);
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        byte_sel  = job_r.data_byte;
        crc_nxt   = crc_feed(crc_r, byte_sel);
        phase_nxt = PH_CRC3;
      end
      PH_CRC3: begin
        byte_sel  = crc_r[31:24];
        phase_nxt = PH_CRC2;
      end
      PH_CRC2: begin
        byte_sel  = crc_r[23:16];
        phase_nxt = PH_CRC1;
      end
      PH_CRC1: begin
        byte_sel  = crc_r[15:8];
        phase_nxt = PH_CRC0;
      end
      PH_CRC0: begin
        byte_sel  = crc_r[7:0];
        crc_nxt   = 32'h0;
        phase_nxt = PH_CRC0;
      end
      default: begin
        byte_sel  = job_r.data_byte;
        phase_nxt = PH_CRC0;
      end
    endcase
  end

  assign emit       = busy_r && (!out_valid_r || out_ready);
  assign final_byte = ((phase_r == PH_DATA) && !job_r.last) || (phase_r == PH_CRC0);
  assign job_ready  = !busy_r || (emit && final_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_HDR_HI;
      crc_r       <= 32'h0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        crc_r       <= crc_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (job_valid && job_ready) begin
        busy_r  <= 1'b1;
        phase_r <= job.first ? PH_HDR_HI : PH_DATA;
      end else if (emit) begin
        if (final_byte) begin
          busy_r <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
    end
    if (emit) begin
      out_r.out_byte     <= byte_sel;
      out_r.end_of_frame <= (phase_r == PH_CRC0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== hdl/length_crc32_frame_builder_top.sv =====
// Top level of the length-prefixed CRC-32 frame builder.
// Tracks frame position and feeds the byte sequencer. Depends on lcfb_pkg, lcfb_emitter.
//
// Each accepted payload byte yields one to seven output items: on a frame's
// first byte a 2-byte big-endian length header (0 becomes 1, capped at
// MAX_PAYLOAD), then the byte, and after the frame's last byte a 4-byte
// big-endian CRC-32 (poly 04C11DB7, MSB first, init 0, no final xor) over
// header and payload, end_of_frame set on its last byte. The output side
// runs at one item per cycle while out_ready is high, so mid-frame bytes
// then flow at one per cycle; an item that opens a frame holds the input
// while its header goes out and one that closes it while its CRC goes out.
`default_nettype none

module length_crc32_frame_builder_top import lcfb_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 65535
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  logic        inside_r, inside_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] len_raw, len_sat;
  logic        accept;
  job_t        job;

  always_comb begin
    len_raw = (in_data.frame_length == 16'h0) ? 16'h1 : in_data.frame_length;
    len_sat = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
    left_nxt   = inside_r ? (left_r - 16'h1) : (len_sat - 16'h1);
    inside_nxt = (left_nxt != 16'h0);

    job.data_byte = in_data.data_byte;
    job.hdr_len   = len_sat;
    job.first     = !inside_r;
    job.last      = (left_nxt == 16'h0);
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      left_r   <= 16'h0;
    end else if (accept) begin
      inside_r <= inside_nxt;
      left_r   <= left_nxt;
    end
  end

  lcfb_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (in_valid),
    .job       (job),
    .job_ready (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/tb_length_crc32_frame_builder_top.sv =====
// Testbench for length_crc32_frame_builder_top: frames are predicted per accepted item and
// compared byte by byte. The sender works in bursts; the receiver stalls on its own pattern.
// Depends on lcfb_pkg and the frame builder RTL.
`timescale 1ns / 100ps

module tb_length_crc32_frame_builder_top import lcfb_pkg::*;;

  localparam int unsigned MAX_PAYLOAD  = 65535;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          LONG_HOLD    = 300;
  localparam int          HOLD_AFTER   = 150;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          RANDOM_ITEMS = 420;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FIFTH, RX_SPARSE} rx_mode_e;

  // running frame prediction and the queue of framed bytes still to arrive
  class frame_byte_board;
    out_item_t   framed_bytes_q[$];
    logic [31:0] crc_acc;
    logic [15:0] bytes_to_go;
    bit          in_frame;
    int          mismatch_count;
    int          bytes_checked;

    function new();
      crc_acc        = '0;
      bytes_to_go    = '0;
      in_frame       = 1'b0;
      mismatch_count = 0;
      bytes_checked  = 0;
    endfunction

    static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h0};
      for (int k = 0; k < 8; k++) c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      return c;
    endfunction

    function void expect_byte(logic [7:0] b, logic eof);
      framed_bytes_q.push_back(out_item_t'{out_byte: b, end_of_frame: eof});
    endfunction

    function void take_payload_byte(in_item_t item);
      int unsigned span;
      if (!in_frame) begin
        span = (item.frame_length == 16'd0) ? 1 : item.frame_length;
        if (span > MAX_PAYLOAD) span = MAX_PAYLOAD;
        crc_acc = crc_step(32'h0, span[15:8]);
        crc_acc = crc_step(crc_acc, span[7:0]);
        expect_byte(span[15:8], 1'b0);
        expect_byte(span[7:0], 1'b0);
        bytes_to_go = span[15:0];
        in_frame    = 1'b1;
      end
      crc_acc = crc_step(crc_acc, item.data_byte);
      expect_byte(item.data_byte, 1'b0);
      if (bytes_to_go != 16'd0) bytes_to_go = bytes_to_go - 16'd1;
      if (bytes_to_go == 16'd0) begin
        expect_byte(crc_acc[31:24], 1'b0);
        expect_byte(crc_acc[23:16], 1'b0);
        expect_byte(crc_acc[15:8], 1'b0);
        expect_byte(crc_acc[7:0], 1'b1);
        crc_acc  = '0;
        in_frame = 1'b0;
      end
    endfunction

    function void match_framed_byte(out_item_t got);
      out_item_t want;
      if (framed_bytes_q.size() == 0) begin
        $display("%0t: unexpected item byte %02h eof %0b, nothing expected",
                 $time, got.out_byte, got.end_of_frame);
        mismatch_count++;
        return;
      end
      want = framed_bytes_q.pop_front();
      bytes_checked++;
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, got.out_byte);
        mismatch_count++;
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        $display("%0t: end_of_frame expected %0b actual %0b",
                 $time, want.end_of_frame, got.end_of_frame);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return framed_bytes_q.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  frame_byte_board board = new();
  in_item_t        payload_q[$];
  int              cycle_count = 0;

  length_crc32_frame_builder_top #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.take_payload_byte(in_data);
      if (out_valid && out_ready) board.match_framed_byte(out_data);
    end
  end

  task automatic push_item(input logic [7:0] d, input logic [15:0] len);
    payload_q.push_back(in_item_t'{data_byte: d, frame_length: len});
  endtask

  task automatic push_random_frame(input logic [15:0] len_field);
    int body;
    body = (len_field == 16'd0) ? 1 : len_field;
    push_item(8'($urandom), len_field);
    for (int i = 1; i < body; i++) push_item(8'($urandom), 16'($urandom));
  endtask

  task automatic build_stimulus();
    int          big_at;
    int          nframes;
    int          pick;
    logic [15:0] len;
    // zero length, one byte, data extremes, ignored length on later bytes
    push_item(8'h00, 16'h0000);
    push_item(8'hFF, 16'h0001);
    push_item(8'hA5, 16'h0000);
    push_item(8'hFF, 16'h0002);
    push_item(8'h00, 16'hFFFF);
    push_item(8'h80, 16'h0005);
    push_item(8'h01, 16'h0000);
    push_item(8'h7F, 16'hFFFF);
    push_item(8'hFE, 16'h0001);
    push_item(8'h55, 16'hAAAA);
    push_item(8'hFF, 16'h0003);
    push_item(8'hFF, 16'h5555);
    push_item(8'hFF, 16'h0000);
    push_item(8'h00, 16'h0001);

    big_at  = $urandom_range(3, 30);
    nframes = 0;
    while (payload_q.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (nframes == big_at) len = 16'($urandom_range(256, 300));
      else if (pick < 2) len = 16'd0;
      else if (pick < 16) len = 16'($urandom_range(1, 8));
      else len = 16'($urandom_range(9, 40));
      push_random_frame(len);
      nframes++;
    end

    // longest header; this frame stays open at the end of the run
    push_item(8'($urandom), 16'hFFFF);
    repeat (6) push_item(8'($urandom), 16'($urandom));
  endtask

  task automatic offer_byte(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       phase;
    bit       long_hold_done;
    bit       rdy;
    phase          = 0;
    long_hold_done = 1'b0;
    forever begin
      if (!long_hold_done && board.bytes_checked >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 64);
      repeat (span) begin
        case (mode)
          RX_OPEN: begin
            rdy = 1'b1;
          end
          RX_COIN: begin
            rdy = 1'($urandom_range(0, 1));
          end
          RX_EVERY_FIFTH: begin
            rdy = (phase % 5) != 4;
          end
          default: begin
            rdy = ($urandom_range(0, 3) == 0);
          end
        endcase
        phase++;
        out_ready <= rdy;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : sender
    int burst_left;
    int gap;
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = 0;
    foreach (payload_q[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      offer_byte(payload_q[i]);
      burst_left--;
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
